// File: rtl/scag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scag_pkg;

  localparam int MAX_DIMS_DEF = 4;
  localparam int IDX_W        = 32;
  localparam int OFF_W        = 34;
  localparam int FLD_W        = 16;
  localparam int PACK_W       = 64;
  localparam int DIMS_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int DIV_BITS     = 4;
  localparam int DIV_STEPS    = IDX_W / DIV_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_DST_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_DIMS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SIZES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_SIZES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT  = 3'd6;

endpackage

`default_nettype wire

// File: rtl/strided_copy_address_generator_top.sv
// Stages: range check, the coordinate-split dividers, coordinate times stride, sum and output register.
// Throughput: one request per cycle; each stall holds only the stages behind it.
// Coordinate split: per dimension above 0 a restoring divider, 4 quotient bits per stage.
// Reset (rst_n low, synchronous): pipeline emptied, dims = 1, sizes, strides and count = 0.
`timescale 1ns / 1ps
`default_nettype none

module strided_copy_address_generator_top
  import scag_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PACK_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IDX_W-1:0]     in_element_index,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OFF_W-1:0]          out_src_offset,
  output logic [OFF_W-1:0]          out_dst_offset,
  output logic                      out_in_range,
  output logic                      out_is_final
);

  // Divides needed: dimensions MAX_DIMS-1 .. 1, dimension 0 takes the final quotient.
  localparam int NDIV  = MAX_DIMS - 1;
  localparam int DSTG  = NDIV * DIV_STEPS;
  localparam int NST   = DSTG + 3;
  localparam int S_MUL = DSTG + 1;
  localparam int S_OUT = DSTG + 2;

  typedef struct packed {
    logic [FLD_W-1:0]               rem;
    logic [IDX_W-1:0]               wq;   // dividend shifts out, quotient shifts in
    logic [MAX_DIMS-1:0][FLD_W-1:0] coord;
  } side_t;

  typedef struct packed {
    logic  in_range;
    logic  is_final;
    side_t src;
    side_t dst;
  } div_t;

  typedef struct packed {
    logic                           in_range;
    logic                           is_final;
    logic [MAX_DIMS-1:0][OFF_W-1:0] src_p;
    logic [MAX_DIMS-1:0][OFF_W-1:0] dst_p;
  } mul_t;

  // ---------------- configuration registers ----------------
  logic [DIMS_W-1:0] dst_dims_r, src_dims_r;
  logic [PACK_W-1:0] dst_sizes_r, dst_strides_r, src_sizes_r, src_strides_r;
  logic [IDX_W-1:0]  elem_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_dims_r    <= DIMS_W'(1);
      src_dims_r    <= DIMS_W'(1);
      dst_sizes_r   <= '0;
      dst_strides_r <= '0;
      src_sizes_r   <= '0;
      src_strides_r <= '0;
      elem_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DST_DIMS:    dst_dims_r    <= cfg_wdata[DIMS_W-1:0];
        REG_SRC_DIMS:    src_dims_r    <= cfg_wdata[DIMS_W-1:0];
        REG_DST_SIZES:   dst_sizes_r   <= cfg_wdata;
        REG_DST_STRIDES: dst_strides_r <= cfg_wdata;
        REG_SRC_SIZES:   src_sizes_r   <= cfg_wdata;
        REG_SRC_STRIDES: src_strides_r <= cfg_wdata;
        REG_ELEM_COUNT:  elem_count_r  <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // dimension counts above MAX_DIMS saturate
  logic [DIMS_W-1:0] dst_dims_eff, src_dims_eff;
  assign dst_dims_eff = (dst_dims_r > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dst_dims_r;
  assign src_dims_eff = (src_dims_r > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : src_dims_r;

  // unused dims divide by 1; a zero size also counts as 1
  function automatic logic [FLD_W-1:0] eff_size(input logic [DIMS_W-1:0] dims,
                                                input logic [PACK_W-1:0] sizes,
                                                input int k);
    logic [FLD_W-1:0] f;
    f = sizes[k*FLD_W +: FLD_W];
    if (dims <= DIMS_W'(k) || f == '0) begin
      f = FLD_W'(1);
    end
    return f;
  endfunction

  // unused dims contribute nothing
  function automatic logic [FLD_W-1:0] eff_stride(input logic [DIMS_W-1:0] dims,
                                                  input logic [PACK_W-1:0] strides,
                                                  input int k);
    logic [FLD_W-1:0] f;
    f = strides[k*FLD_W +: FLD_W];
    if (dims <= DIMS_W'(k)) begin
      f = '0;
    end
    return f;
  endfunction

  // DIV_BITS steps of restoring division; rem stays below the divisor
  function automatic side_t div_step(input side_t s, input logic [FLD_W-1:0] d);
    side_t            r;
    logic [FLD_W:0]   t;
    r = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {r.rem, r.wq[IDX_W-1]};
      if (t >= {1'b0, d}) begin
        r.rem = FLD_W'(t - {1'b0, d});
        r.wq  = {r.wq[IDX_W-2:0], 1'b1};
      end else begin
        r.rem = t[FLD_W-1:0];
        r.wq  = {r.wq[IDX_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // ---------------- pipeline handshake ----------------
  logic [NST-1:0] valid_r;
  logic [NST-1:0] free;

  // a stage can load when empty or when its content moves on this cycle
  always_comb begin
    free[NST-1] = !valid_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      free[i] = !valid_r[i] || free[i+1];
    end
  end

  assign in_ready = free[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (free[0]) valid_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (free[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  // ---------------- stage 0: range check, load dividend ----------------
  div_t div_r [0:DSTG];
  div_t entry_nxt;

  always_comb begin
    entry_nxt          = '0;
    entry_nxt.in_range = in_element_index < elem_count_r;
    entry_nxt.is_final = ({1'b0, in_element_index} + 33'd1) == {1'b0, elem_count_r};
    entry_nxt.src.wq   = in_element_index;
    entry_nxt.dst.wq   = in_element_index;
  end

  always_ff @(posedge clk) begin
    if (free[0]) div_r[0] <= entry_nxt;
  end

  // ---------------- divider stages ----------------
  // divide J peels dimension K = MAX_DIMS-1-J; its remainder is that coordinate
  for (genvar gi = 1; gi <= DSTG; gi++) begin : g_div
    localparam int J    = (gi - 1) / DIV_STEPS;
    localparam int K    = MAX_DIMS - 1 - J;
    localparam bit LAST = ((gi - 1) % DIV_STEPS) == (DIV_STEPS - 1);

    div_t stg_nxt;

    always_comb begin
      stg_nxt     = div_r[gi-1];
      stg_nxt.src = div_step(div_r[gi-1].src, eff_size(src_dims_eff, src_sizes_r, K));
      stg_nxt.dst = div_step(div_r[gi-1].dst, eff_size(dst_dims_eff, dst_sizes_r, K));
      if (LAST) begin
        stg_nxt.src.coord[K] = stg_nxt.src.rem;
        stg_nxt.dst.coord[K] = stg_nxt.dst.rem;
        stg_nxt.src.rem      = '0;
        stg_nxt.dst.rem      = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (free[gi]) div_r[gi] <= stg_nxt;
    end
  end

  // ---------------- coordinate times stride ----------------
  mul_t mul_r, mul_nxt;

  always_comb begin
    logic [IDX_W+FLD_W-1:0] p0s, p0d;
    logic [2*FLD_W-1:0]     pks, pkd;
    mul_nxt          = '0;
    mul_nxt.in_range = div_r[DSTG].in_range;
    mul_nxt.is_final = div_r[DSTG].is_final;
    p0s = div_r[DSTG].src.wq * eff_stride(src_dims_eff, src_strides_r, 0);
    p0d = div_r[DSTG].dst.wq * eff_stride(dst_dims_eff, dst_strides_r, 0);
    mul_nxt.src_p[0] = p0s[OFF_W-1:0];
    mul_nxt.dst_p[0] = p0d[OFF_W-1:0];
    for (int k = 1; k < MAX_DIMS; k++) begin
      pks = div_r[DSTG].src.coord[k] * eff_stride(src_dims_eff, src_strides_r, k);
      pkd = div_r[DSTG].dst.coord[k] * eff_stride(dst_dims_eff, dst_strides_r, k);
      mul_nxt.src_p[k] = OFF_W'(pks);
      mul_nxt.dst_p[k] = OFF_W'(pkd);
    end
  end

  always_ff @(posedge clk) begin
    if (free[S_MUL]) mul_r <= mul_nxt;
  end

  // ---------------- sum, gate, output register ----------------
  logic [OFF_W-1:0] src_sum, dst_sum;
  logic [OFF_W-1:0] src_off_r, dst_off_r;
  logic             in_range_r, is_final_r;

  always_comb begin
    src_sum = '0;
    dst_sum = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      src_sum = src_sum + mul_r.src_p[k];
      dst_sum = dst_sum + mul_r.dst_p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (free[S_OUT]) begin
      src_off_r  <= mul_r.in_range ? src_sum : '0;
      dst_off_r  <= mul_r.in_range ? dst_sum : '0;
      in_range_r <= mul_r.in_range;
      is_final_r <= mul_r.in_range && mul_r.is_final;
    end
  end

  assign out_valid      = valid_r[S_OUT];
  assign out_src_offset = src_off_r;
  assign out_dst_offset = dst_off_r;
  assign out_in_range   = in_range_r;
  assign out_is_final   = is_final_r;

endmodule

`default_nettype wire

// File: rtl/scag_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module scag_checker
  import scag_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OFF_W-1:0] out_src_offset,
  input wire logic [OFF_W-1:0] out_dst_offset,
  input wire logic             out_in_range,
  input wire logic             out_is_final
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_src_offset == '0 && out_dst_offset == '0)
    else $error("out of range request with nonzero offset");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final |-> out_in_range)
    else $error("final flag outside range");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid result right after reset");

endmodule

bind strided_copy_address_generator_top scag_checker u_scag_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_src_offset (out_src_offset),
  .out_dst_offset (out_dst_offset),
  .out_in_range   (out_in_range),
  .out_is_final   (out_is_final)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import scag_pkg::*;

  // Register index past the end of the map
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // Expected address pair for one accepted request
  typedef struct packed {
    logic [OFF_W-1:0] src_off;
    logic [OFF_W-1:0] dst_off;
    logic             in_range;
    logic             is_final;
  } addr_pair_t;

  // Register shadow, updated on each cfg write
  logic [DIMS_W-1:0] sh_dst_dims, sh_src_dims;
  logic [PACK_W-1:0] sh_dst_sizes, sh_dst_strides, sh_src_sizes, sh_src_strides;
  logic [IDX_W-1:0]  sh_count;

  int fail_count = 0;

  function automatic void report(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endfunction

  // Offset of one side: split the row-major index by suffix products, dot with strides.
  function automatic logic [OFF_W-1:0] side_addr(input logic [IDX_W-1:0] idx,
      input logic [DIMS_W-1:0] dims_reg, input logic [PACK_W-1:0] sizes,
      input logic [PACK_W-1:0] strides);
    logic [63:0] prod [4];
    logic [63:0] acc, rest, sz, coord;
    logic [OFF_W-1:0] off;
    int d;
    d = (dims_reg > 4) ? 4 : int'(dims_reg);
    acc = 1;
    rest = 64'(idx);
    off = '0;
    for (int k = d - 1; k >= 0; k--) begin
      prod[k] = acc;
      sz = 64'(sizes[k*FLD_W +: FLD_W]);
      if (sz == 0) sz = 1;
      acc = acc * sz;
    end
    for (int k = 0; k < d; k++) begin
      coord = rest / prod[k];
      rest = rest % prod[k];
      off = off + OFF_W'(coord * 64'(strides[k*FLD_W +: FLD_W]));
    end
    return off;
  endfunction

  function automatic addr_pair_t predict_pair(input logic [IDX_W-1:0] idx);
    addr_pair_t r;
    r = '0;
    if (idx < sh_count) begin
      r.src_off  = side_addr(idx, sh_src_dims, sh_src_sizes, sh_src_strides);
      r.dst_off  = side_addr(idx, sh_dst_dims, sh_dst_sizes, sh_dst_strides);
      r.in_range = 1'b1;
      r.is_final = (33'(idx) + 33'd1 == 33'(sh_count));
    end
    return r;
  endfunction

  class addr_scoreboard;
    addr_pair_t pending[$];

    function void note_request(input logic [IDX_W-1:0] idx);
      pending.push_back(predict_pair(idx));
    endfunction

    function void check_result(input addr_pair_t got);
      addr_pair_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(got.src_off), 0);
        return;
      end
      want = pending.pop_front();
      if (got.src_off !== want.src_off) report("src_offset", 64'(got.src_off), 64'(want.src_off));
      if (got.dst_off !== want.dst_off) report("dst_offset", 64'(got.dst_off), 64'(want.dst_off));
      if (got.in_range !== want.in_range) report("in_range", 64'(got.in_range), 64'(want.in_range));
      if (got.is_final !== want.is_final) report("is_final", 64'(got.is_final), 64'(want.is_final));
    endfunction
  endclass

  addr_scoreboard sb = new();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PACK_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_element_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OFF_W-1:0] out_src_offset, out_dst_offset;
  logic out_in_range, out_is_final;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  strided_copy_address_generator_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_element_index(in_element_index), .out_valid(out_valid), .out_ready(out_ready),
    .out_src_offset(out_src_offset), .out_dst_offset(out_dst_offset),
    .out_in_range(out_in_range), .out_is_final(out_is_final)
  );

  // Idle controls: 29% gaps, except during a no-idle stretch
  bit no_idle = 1'b0;
  int quiet_cycles = 0;
  localparam int WATCHDOG = 3000;

  // Sink side: random backpressure, check on each accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_src_offset, out_dst_offset, out_in_range, out_is_final});
    out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // Watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One register write; the enable drops for a cycle before the next write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DST_DIMS:    sh_dst_dims = val[DIMS_W-1:0];
      REG_SRC_DIMS:    sh_src_dims = val[DIMS_W-1:0];
      REG_DST_SIZES:   sh_dst_sizes = val;
      REG_DST_STRIDES: sh_dst_strides = val;
      REG_SRC_SIZES:   sh_src_sizes = val;
      REG_SRC_STRIDES: sh_src_strides = val;
      REG_ELEM_COUNT:  sh_count = val[IDX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One request, with a random gap in front; holds valid until accepted
  task automatic send_index(input logic [IDX_W-1:0] idx);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(idx);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random sizes, mostly small so coordinates actually change
  function automatic logic [PACK_W-1:0] rand_sizes(input int mode);
    logic [PACK_W-1:0] v;
    for (int k = 0; k < 4; k++) begin
      case (mode)
        0: v[k*16 +: 16] = 16'($urandom_range(5));
        1: v[k*16 +: 16] = 16'($urandom_range(40));
        default: v[k*16 +: 16] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    logic [IDX_W-1:0] c;
    c = sh_count;
    case ($urandom_range(9))
      0: return $urandom;
      1: return (c == 0) ? 0 : c - 1;
      2: return c;
      default: return (c == 0) ? $urandom_range(3) : IDX_W'($urandom) % c;
    endcase
  endfunction

  initial begin
    int phase;
    sh_dst_dims = 1; sh_src_dims = 1; sh_dst_sizes = 0; sh_dst_strides = 0;
    sh_src_sizes = 0; sh_src_strides = 0; sh_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: count zero, so every index is out of range
    send_index(0);
    send_index('1);
    drain();

    // Directed: zero sizes, saturated and zero dims, max strides, overflow
    write_reg(REG_DST_DIMS, 7);
    write_reg(REG_SRC_DIMS, 0);
    write_reg(REG_DST_SIZES, 64'h0003_0000_FFFF_0002);
    write_reg(REG_DST_STRIDES, '1);
    write_reg(REG_SRC_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SRC_STRIDES, 64'h0001_0002_0003_0004);
    write_reg(REG_ELEM_COUNT, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED, '1);   // ignored
    send_index(0);
    send_index(1);
    send_index(32'hFFFF_FFFD);
    send_index(32'hFFFF_FFFE);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0000);
    send_index(32'h5555_5555);
    send_index(32'hAAAA_AAAA);
    drain();
    write_reg(REG_SRC_DIMS, 4);
    write_reg(REG_DST_DIMS, 1);
    write_reg(REG_ELEM_COUNT, 1);
    send_index(0);
    send_index(1);
    send_index(32'hFFFF_FFFF);
    drain();

    // Random phases with fresh configurations
    for (phase = 0; phase < 14; phase++) begin
      write_reg(REG_DST_DIMS, $urandom_range(7));
      write_reg(REG_SRC_DIMS, $urandom_range(7));
      write_reg(REG_DST_SIZES, rand_sizes(phase % 3));
      write_reg(REG_SRC_SIZES, rand_sizes((phase + 1) % 3));
      write_reg(REG_DST_STRIDES, (phase % 4 == 3) ? '1 : {$urandom, $urandom});
      write_reg(REG_SRC_STRIDES, (phase % 5 == 4) ? '0 : {$urandom, $urandom});
      write_reg(REG_ELEM_COUNT, (phase % 4 == 0) ? $urandom :
                                (phase % 7 == 6) ? 0 : $urandom_range(2000));
      no_idle = (phase == 5);
      for (int n = 0; n < 125; n++) send_index(rand_index());
      no_idle = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
